// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion helpers
// checks clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define HTFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the following edge
`define HTFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/htfd_pkg.sv =====
// ----------------------------------------------------------------------------
// htfd_pkg
// shared types, constants and the crc-8 step for the sensor frame decoder
// ----------------------------------------------------------------------------
`default_nettype none

package htfd_pkg;

    // configuration register indexes
    localparam logic CFG_CRC_POLYNOMIAL   = 1'b0;
    localparam logic CFG_CRC_CHECK_ENABLE = 1'b1;

    localparam logic [7:0] CRC_POLY_RESET = 8'h31;
    localparam logic [7:0] CRC_INIT       = 8'hFF;

    // byte slots inside one reading
    localparam logic [2:0] POS_TEMP_HIGH  = 3'd0;
    localparam logic [2:0] POS_TEMP_LOW   = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC   = 3'd2;
    localparam logic [2:0] POS_HUMID_HIGH = 3'd3;
    localparam logic [2:0] POS_HUMID_LOW  = 3'd4;
    localparam logic [2:0] POS_HUMID_CRC  = 3'd5;

    localparam logic KIND_TEMP  = 1'b0;
    localparam logic KIND_HUMID = 1'b1;

    // conversion: floor(scale * raw / 65535), minus offset for temperature
    localparam int PROD_W = 31;
    localparam int VAL_W  = 15;
    localparam logic [VAL_W-1:0] TEMP_SCALE  = 15'd17500;
    localparam logic [VAL_W-1:0] HUMID_SCALE = 15'd10000;
    localparam logic [VAL_W-1:0] TEMP_OFFSET = 15'd4500;

    typedef struct packed {
        logic        kind;
        logic [15:0] raw;
        logic        ok;
    } word_t;

    // one byte through a msb-first crc-8
    function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                               input logic [7:0] data,
                                               input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ poly;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/htfd_scale.sv =====
// ----------------------------------------------------------------------------
// htfd_scale
// two-stage conversion of a raw word: constant multiply, then /65535 and temperature offset
// ----------------------------------------------------------------------------
`default_nettype none

module htfd_scale (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire htfd_pkg::word_t                 in_word,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 word_kind,
    output logic [15:0]                          raw_word,
    output logic                                 crc_ok,
    output logic signed [htfd_pkg::VAL_W-1:0]    scaled_value
);

`include "assert_macros.svh"

    logic                             prod_valid_reg;
    htfd_pkg::word_t                  prod_word_reg;
    logic [htfd_pkg::PROD_W-1:0]      prod_reg;
    logic [htfd_pkg::PROD_W-1:0]      prod_next;
    logic [htfd_pkg::VAL_W-1:0]       scale;

    logic                             out_valid_reg;
    htfd_pkg::word_t                  out_word_reg;
    logic [htfd_pkg::VAL_W-1:0]       out_value_reg;
    logic [htfd_pkg::VAL_W-1:0]       value_next;
    logic [htfd_pkg::PROD_W-1:0]      div_sum;
    logic [htfd_pkg::VAL_W-1:0]       quot;

    logic                             out_en;
    logic                             prod_en;

    assign out_en   = !out_valid_reg || !out_stall;
    assign prod_en  = !prod_valid_reg || out_en;
    assign in_stall = !prod_en;

    assign scale     = (in_word.kind == htfd_pkg::KIND_HUMID) ?
                       htfd_pkg::HUMID_SCALE : htfd_pkg::TEMP_SCALE;
    assign prod_next = htfd_pkg::PROD_W'(in_word.raw) * htfd_pkg::PROD_W'(scale);

    // exact floor(x / 65535) for x up to 65535 * 17500: (x + (x >> 16) + 1) >> 16
    assign div_sum = prod_reg + (prod_reg >> 16) + htfd_pkg::PROD_W'(1);
    assign quot    = div_sum[htfd_pkg::PROD_W-1:16];
    assign value_next = (prod_word_reg.kind == htfd_pkg::KIND_HUMID) ?
                        quot : quot - htfd_pkg::TEMP_OFFSET;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_en)
                prod_valid_reg <= in_valid;
            if (out_en)
                out_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_en && in_valid)
        begin
            prod_word_reg <= in_word;
            prod_reg      <= prod_next;
        end
        if (out_en && prod_valid_reg)
        begin
            out_word_reg  <= prod_word_reg;
            out_value_reg <= value_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign word_kind    = out_word_reg.kind;
    assign raw_word     = out_word_reg.raw;
    assign crc_ok       = out_word_reg.ok;
    assign scaled_value = out_value_reg;

    `HTFD_ASSERT(a_humid_range,
        !(out_valid_reg && out_word_reg.kind == htfd_pkg::KIND_HUMID) ||
        (out_value_reg <= htfd_pkg::HUMID_SCALE),
        "humidity value out of range")
    `HTFD_ASSERT_NEXT(a_prod_advance, prod_valid_reg && out_en, out_valid_reg,
        "product stage lost a transfer")
    `HTFD_ASSERT_NEXT(a_out_hold, out_valid_reg && out_stall, out_valid_reg,
        "stalled result dropped")

endmodule

`default_nettype wire

// ===== rtl/humidity_temp_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// byte-wise decoder for a temperature/humidity sensor reading with crc-8 check
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_stall) carries one received byte per transfer,
//   frame_start marks the first byte of a reading. the six bytes are
//   temperature high, low, crc, then humidity high, low, crc.
//   after each crc byte one result transfer leaves on out_valid/out_stall:
//   word kind, raw word, crc verdict and the scaled value.
//   one byte per cycle is accepted while in_stall is low; a result passes
//   the byte stage, which loads at its crc byte transfer, then the multiply
//   stage, then the divide and offset stage, which drives the outputs. bytes
//   that close no word give no result.
//   config writes (cfg_write, cfg_index, cfg_data) take effect at once and
//   are meant for idle periods only.
//   reset clears the byte position, loads crc 0xff, polynomial 0x31 and
//   enables the check. when out_stall holds, results queue in the stages and
//   in_stall rises only once every stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_temp_frame_decoder (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic                            cfg_index,
    input  wire logic [7:0]                      cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [7:0]                      rx_byte,
    input  wire logic                            frame_start,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 word_kind,
    output logic [15:0]                          raw_word,
    output logic                                 crc_ok,
    output logic signed [htfd_pkg::VAL_W-1:0]    scaled_value
);

`include "assert_macros.svh"

    logic [7:0]       poly_reg;
    logic             check_en_reg;

    logic [2:0]       pos_reg;
    logic [2:0]       pos_next;
    logic [7:0]       crc_reg;
    logic [7:0]       crc_next;
    logic [7:0]       high_reg;
    logic [7:0]       high_next;
    logic [7:0]       low_reg;
    logic [7:0]       low_next;

    logic [2:0]       pos_eff;
    logic [7:0]       crc_base;
    logic [7:0]       crc_step;
    logic             is_crc;

    logic             mid_valid_reg;
    htfd_pkg::word_t  mid_word_reg;
    htfd_pkg::word_t  mid_word_next;
    logic             mid_en;
    logic             scale_stall;
    logic             accept;

    assign mid_en   = !mid_valid_reg || !scale_stall;
    assign in_stall = !mid_en;
    assign accept   = in_valid && mid_en;

    // frame start restarts the reading before this byte is taken
    always_comb
    begin
        if (frame_start || pos_reg > htfd_pkg::POS_HUMID_CRC)
            pos_eff = htfd_pkg::POS_TEMP_HIGH;
        else
            pos_eff = pos_reg;
        crc_base = frame_start ? htfd_pkg::CRC_INIT : crc_reg;
    end

    assign crc_step = htfd_pkg::crc8_update(crc_base, rx_byte, poly_reg);

    always_comb
    begin
        pos_next  = pos_eff + 3'd1;
        crc_next  = crc_step;
        high_next = high_reg;
        low_next  = low_reg;
        is_crc    = 1'b0;
        case (pos_eff)
            htfd_pkg::POS_TEMP_HIGH, htfd_pkg::POS_HUMID_HIGH:
                high_next = rx_byte;
            htfd_pkg::POS_TEMP_LOW, htfd_pkg::POS_HUMID_LOW:
                low_next = rx_byte;
            htfd_pkg::POS_TEMP_CRC:
            begin
                is_crc   = 1'b1;
                crc_next = htfd_pkg::CRC_INIT;
                pos_next = htfd_pkg::POS_HUMID_HIGH;
            end
            htfd_pkg::POS_HUMID_CRC:
            begin
                is_crc   = 1'b1;
                crc_next = htfd_pkg::CRC_INIT;
                pos_next = htfd_pkg::POS_TEMP_HIGH;
            end
            default:
                pos_next = pos_eff + 3'd1;
        endcase
    end

    always_comb
    begin
        mid_word_next.kind = (pos_eff == htfd_pkg::POS_HUMID_CRC) ?
                             htfd_pkg::KIND_HUMID : htfd_pkg::KIND_TEMP;
        mid_word_next.raw  = {high_reg, low_reg};
        mid_word_next.ok   = !check_en_reg || (crc_base == rx_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg      <= htfd_pkg::CRC_POLY_RESET;
            check_en_reg  <= 1'b1;
            pos_reg       <= htfd_pkg::POS_TEMP_HIGH;
            crc_reg       <= htfd_pkg::CRC_INIT;
            high_reg      <= 8'd0;
            low_reg       <= 8'd0;
            mid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    htfd_pkg::CFG_CRC_POLYNOMIAL:   poly_reg <= cfg_data;
                    htfd_pkg::CFG_CRC_CHECK_ENABLE: check_en_reg <= cfg_data[0];
                    default:                        poly_reg <= poly_reg;
                endcase
            end
            if (accept)
            begin
                pos_reg  <= pos_next;
                crc_reg  <= crc_next;
                high_reg <= high_next;
                low_reg  <= low_next;
            end
            if (mid_en)
                mid_valid_reg <= accept && is_crc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_crc)
            mid_word_reg <= mid_word_next;
    end

    htfd_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (mid_valid_reg),
        .in_stall     (scale_stall),
        .in_word      (mid_word_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .word_kind    (word_kind),
        .raw_word     (raw_word),
        .crc_ok       (crc_ok),
        .scaled_value (scaled_value)
    );

    `HTFD_ASSERT(a_pos_range, pos_reg <= htfd_pkg::POS_HUMID_CRC,
        "byte position out of range")
    `HTFD_ASSERT_NEXT(a_word_issued, accept && is_crc, mid_valid_reg,
        "crc byte transfer gave no word")
    `HTFD_ASSERT_NEXT(a_crc_restart, accept && is_crc, crc_reg == htfd_pkg::CRC_INIT,
        "crc not restarted after word")

endmodule

`default_nettype wire
